FILE: rtl/stereo_comb_allpass_reverb_macros.svh
// Assertion macros shared by the reverb RTL.
`ifndef STEREO_COMB_ALLPASS_REVERB_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SCAR_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("reverb assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SCAR_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("reverb assertion failed");

`endif

FILE: rtl/scar_pkg.sv
// Package with constants, types and helper functions of the stereo reverb.
`default_nettype none

package scar_pkg;

    localparam int COMBS_PER_SIDE      = 4;
    localparam int ALLPASSES_PER_SIDE  = 2;
    localparam int NCOMB               = 2 * COMBS_PER_SIDE;
    localparam int NAP                 = 2 * ALLPASSES_PER_SIDE;

    localparam int DEF_MAX_COMB_LEN    = 8192;
    localparam int DEF_MAX_ALLPASS_LEN = 2048;
    localparam int DEF_SAMPLE_BITS     = 24;

    // Configuration port.
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd3;

    localparam logic [14:0] RST_FEEDBACK = 15'd25887;
    localparam logic [15:0] RST_WET      = 16'd8192;
    localparam logic [15:0] RST_GAIN     = 16'd32768;
    localparam logic [16:0] RST_SCALE    = 17'd16384;

    localparam logic [14:0] FB_MIN     = 15'd16384;
    localparam logic [14:0] FB_MAX     = 15'd31457;
    localparam logic [15:0] UNITY      = 16'd32768;
    localparam logic [15:0] WET_BYPASS = 16'd327;

    // Datapath types.
    typedef logic signed [33:0] mul_a_t;
    typedef logic signed [16:0] coef_t;
    typedef logic signed [50:0] prod_t;
    typedef logic signed [35:0] rnd_t;
    typedef logic signed [36:0] wide_t;
    typedef logic signed [31:0] word_t;

    localparam coef_t Q_IN     = 17'sd13107;
    localparam coef_t Q_DAMP   = 17'sd11469;
    localparam coef_t Q_UNDAMP = 17'sd21299;
    localparam coef_t Q_HALF   = 17'sd16384;

    // Base comb lengths: left lines first, then right.
    function automatic logic [10:0] comb_base(input logic [2:0] k);
        logic [10:0] b;
        case (k)
            3'd0: b = 11'd1116;
            3'd1: b = 11'd1188;
            3'd2: b = 11'd1277;
            3'd3: b = 11'd1356;
            3'd4: b = 11'd1139;
            3'd5: b = 11'd1211;
            3'd6: b = 11'd1301;
            default: b = 11'd1378;
        endcase
        return b;
    endfunction

    // Base allpass lengths: left lines first, then right.
    function automatic logic [8:0] ap_base(input logic [1:0] k);
        logic [8:0] b;
        case (k)
            2'd0: b = 9'd225;
            2'd1: b = 9'd341;
            2'd2: b = 9'd256;
            default: b = 9'd373;
        endcase
        return b;
    endfunction

    // Q15 product rounding: floor((p + 16384) / 32768).
    function automatic rnd_t round15(input prod_t p);
        prod_t t;
        t = p + 51'sd16384;
        return t[50:15];
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic word_t sat32(input wide_t v);
        word_t r;
        if (v > 37'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/stereo_comb_allpass_reverb.sv
// Stereo comb and allpass room reverb with a shared multiply-and-round sequencer.
//
// Channels: the input stream (s_tvalid/s_tready/s_tdata) carries one stereo dry
// frame per item, the output stream (m_tvalid/m_tready/m_tdata) one stereo result.
// The configuration port (cfg_wen/cfg_index/cfg_data) writes feedback, wet level,
// output gain and length scale; write it only while the block is idle.
// Sequencing: one item is worked by a sequencer around a single registered
// multiplier. With the reverb active an item passes the idle state that accepts
// it; per side an input scale step, each of four combs, each of two allpasses
// and the mix; then the output hand-over state. With the reverb bypassed the
// input scale, comb and allpass steps are skipped on both sides.
// s_tready is high only while the sequencer is idle. m_tvalid rises once the
// item is finished, provided the output register is free.
// The result sits in an output register, so the next item is accepted while a
// result still waits; if the receiver stalls, the sequencer holds its finished
// result until the output register is free.
// Reset restores the register defaults and empties every delay line. Delay
// memory needs no clearing pass: a per-line wrap flag makes untouched words read
// as zero, and a length_scale write clears the flags, positions and low-pass state.
`default_nettype none
`include "stereo_comb_allpass_reverb_macros.svh"

module stereo_comb_allpass_reverb
    import scar_pkg::*;
#(
    parameter int MAX_COMB_LEN    = DEF_MAX_COMB_LEN,
    parameter int MAX_ALLPASS_LEN = DEF_MAX_ALLPASS_LEN,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0 up: dry_left, dry_right, zero fill.
    input  wire logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // Fields from bit 0 up: out_left, out_right, zero fill.
    output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]      m_tdata,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CPOS_W   = $clog2(MAX_COMB_LEN);
    localparam int APOS_W   = $clog2(MAX_ALLPASS_LEN);
    localparam int CDEPTH   = NCOMB * MAX_COMB_LEN;
    localparam int ADEPTH   = NAP * MAX_ALLPASS_LEN;
    localparam int CADDR_W  = $clog2(CDEPTH);
    localparam int AADDR_W  = $clog2(ADEPTH);
    localparam rnd_t OUT_HI = rnd_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam rnd_t OUT_LO = -OUT_HI - 36'sd1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_IN   = 4'd1;
    localparam logic [3:0] ST_CRD  = 4'd2;
    localparam logic [3:0] ST_CM1  = 4'd3;
    localparam logic [3:0] ST_CM2  = 4'd4;
    localparam logic [3:0] ST_CM3  = 4'd5;
    localparam logic [3:0] ST_CM4  = 4'd6;
    localparam logic [3:0] ST_ARD  = 4'd7;
    localparam logic [3:0] ST_AP1  = 4'd8;
    localparam logic [3:0] ST_AP2  = 4'd9;
    localparam logic [3:0] ST_MX1  = 4'd10;
    localparam logic [3:0] ST_MX2  = 4'd11;
    localparam logic [3:0] ST_MX3  = 4'd12;
    localparam logic [3:0] ST_MX4  = 4'd13;
    localparam logic [3:0] ST_MX5  = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic        side_reg;
    logic [1:0]  idx_reg;

    logic [14:0] cfg_fb_reg;
    logic [15:0] cfg_wet_reg;
    logic [15:0] cfg_gain_reg;
    logic [16:0] cfg_scale_reg;

    logic signed [SAMPLE_BITS-1:0] dry_l_reg, dry_r_reg;
    logic [14:0] fb_reg;
    logic [15:0] dry_c_reg;
    logic [13:0] wet_c_reg;
    logic [15:0] gain_reg;
    logic        bypass_reg;

    prod_t       prod_reg;
    rnd_t        acc_reg;
    word_t       in_reg;
    word_t       sum_reg;
    word_t       b_reg;
    mul_a_t      mix_reg;
    word_t       comb_rd_reg;
    word_t       ap_rd_reg;
    word_t       lowpass_reg [NCOMB];
    logic [CPOS_W-1:0] cpos_reg [NCOMB];
    logic [NCOMB-1:0]  cwrap_reg;
    logic [APOS_W-1:0] apos_reg [NAP];
    logic [NAP-1:0]    awrap_reg;

    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic        out_valid_reg;

    word_t comb_mem [CDEPTH];
    word_t ap_mem   [ADEPTH];

    logic        accept;
    logic        out_free;
    logic [2:0]  cline;
    logic [1:0]  aline;
    logic [CADDR_W-1:0] caddr;
    logic [AADDR_W-1:0] aaddr;
    word_t       o_c, b_c, cwr, awr;
    rnd_t        prod_rnd;
    mul_a_t      dry_ext;
    mul_a_t      mul_a;
    coef_t       mul_b;

    logic [15:0] wet_sat, gain_sat;
    logic [17:0] wet3;
    logic [36:0] tenth_prod;
    logic [16:0] tenth;
    logic [16:0] wet_p2;
    logic [14:0] fb_clamp;

    logic [27:0] clen_prod;
    logic [13:0] clen_raw;
    logic [CPOS_W-1:0] clen;
    logic [CPOS_W:0]   cpos_inc;
    logic [25:0] alen_prod;
    logic [11:0] alen_raw;
    logic [APOS_W-1:0] alen;
    logic [APOS_W:0]   apos_inc;
    rnd_t        out_rnd;
    logic signed [SAMPLE_BITS-1:0] out_sat;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'({out_r_reg, out_l_reg});

    // Line selection and memory addresses.
    assign cline    = {side_reg, idx_reg};
    assign aline    = {side_reg, idx_reg[0]};
    assign caddr    = CADDR_W'(cline) * CADDR_W'(MAX_COMB_LEN) + CADDR_W'(cpos_reg[cline]);
    assign aaddr    = AADDR_W'(aline) * AADDR_W'(MAX_ALLPASS_LEN) + AADDR_W'(apos_reg[aline]);
    assign o_c      = cwrap_reg[cline] ? comb_rd_reg : 32'sd0;
    assign b_c      = awrap_reg[aline] ? ap_rd_reg : 32'sd0;
    assign prod_rnd = round15(prod_reg);
    assign cwr      = sat32(wide_t'(in_reg) + wide_t'(prod_rnd));
    assign awr      = sat32(wide_t'(sum_reg) + wide_t'(prod_rnd));
    assign dry_ext  = side_reg ? mul_a_t'(dry_r_reg) : mul_a_t'(dry_l_reg);

    // Mix coefficients from the registers; /10 as a reciprocal multiply.
    always_comb
    begin
        wet_sat    = (cfg_wet_reg > UNITY) ? UNITY : cfg_wet_reg;
        gain_sat   = (cfg_gain_reg > UNITY) ? UNITY : cfg_gain_reg;
        wet3       = ({2'b0, wet_sat} << 1) + {2'b0, wet_sat} + 18'd5;
        tenth_prod = {19'b0, wet3} * 37'd104858;
        tenth      = tenth_prod[36:20];
        wet_p2     = {1'b0, wet_sat} + 17'd2;
        if (cfg_fb_reg < FB_MIN)
            fb_clamp = FB_MIN;
        else if (cfg_fb_reg > FB_MAX)
            fb_clamp = FB_MAX;
        else
            fb_clamp = cfg_fb_reg;
    end

    // Delay lengths of the current lines.
    always_comb
    begin
        clen_prod = {6'b0, comb_base(cline)} * {11'b0, cfg_scale_reg};
        clen_raw  = clen_prod[27:14];
        if (clen_raw < 14'd16)
            clen = CPOS_W'(16);
        else if ({18'b0, clen_raw} > 32'(MAX_COMB_LEN - 1))
            clen = CPOS_W'(MAX_COMB_LEN - 1);
        else
            clen = clen_raw[CPOS_W-1:0];
        cpos_inc  = {1'b0, cpos_reg[cline]} + {{CPOS_W{1'b0}}, 1'b1};

        alen_prod = {8'b0, ap_base(aline)} * {9'b0, cfg_scale_reg};
        alen_raw  = alen_prod[25:14];
        if (alen_raw < 12'd8)
            alen = APOS_W'(8);
        else if ({20'b0, alen_raw} > 32'(MAX_ALLPASS_LEN - 1))
            alen = APOS_W'(MAX_ALLPASS_LEN - 1);
        else
            alen = alen_raw[APOS_W-1:0];
        apos_inc  = {1'b0, apos_reg[aline]} + {{APOS_W{1'b0}}, 1'b1};
    end

    // Output saturation to the sample width.
    always_comb
    begin
        out_rnd = prod_rnd;
        if (out_rnd > OUT_HI)
            out_sat = OUT_HI[SAMPLE_BITS-1:0];
        else if (out_rnd < OUT_LO)
            out_sat = OUT_LO[SAMPLE_BITS-1:0];
        else
            out_sat = out_rnd[SAMPLE_BITS-1:0];
    end

    // Operand select of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IN:
            begin
                mul_a = dry_ext;
                mul_b = Q_IN;
            end
            ST_CRD:
            begin
                mul_a = mul_a_t'(lowpass_reg[cline]);
                mul_b = Q_DAMP;
            end
            ST_CM1:
            begin
                mul_a = mul_a_t'(o_c);
                mul_b = Q_UNDAMP;
            end
            ST_CM3:
            begin
                mul_a = mul_a_t'(lowpass_reg[cline]);
                mul_b = coef_t'({2'b0, fb_reg});
            end
            ST_AP1:
            begin
                mul_a = mul_a_t'(b_c);
                mul_b = Q_HALF;
            end
            ST_MX1:
            begin
                mul_a = dry_ext;
                mul_b = coef_t'({1'b0, dry_c_reg});
            end
            ST_MX2:
            begin
                mul_a = bypass_reg ? '0 : mul_a_t'(sum_reg);
                mul_b = coef_t'({3'b0, wet_c_reg});
            end
            ST_MX4:
            begin
                mul_a = mix_reg;
                mul_b = coef_t'({1'b0, gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = (wet_sat <= WET_BYPASS) ? ST_MX1 : ST_IN;
            ST_IN:   state_next = ST_CRD;
            ST_CRD:  state_next = ST_CM1;
            ST_CM1:  state_next = ST_CM2;
            ST_CM2:  state_next = ST_CM3;
            ST_CM3:  state_next = ST_CM4;
            ST_CM4:  state_next = (idx_reg == 2'd3) ? ST_ARD : ST_CRD;
            ST_ARD:  state_next = ST_AP1;
            ST_AP1:  state_next = ST_AP2;
            ST_AP2:  state_next = idx_reg[0] ? ST_MX1 : ST_ARD;
            ST_MX1:  state_next = ST_MX2;
            ST_MX2:  state_next = ST_MX3;
            ST_MX3:  state_next = ST_MX4;
            ST_MX4:  state_next = ST_MX5;
            ST_MX5:
            begin
                if (side_reg)
                    state_next = ST_DONE;
                else
                    state_next = bypass_reg ? ST_MX1 : ST_IN;
            end
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and reverb state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            cfg_fb_reg    <= RST_FEEDBACK;
            cfg_wet_reg   <= RST_WET;
            cfg_gain_reg  <= RST_GAIN;
            cfg_scale_reg <= RST_SCALE;
            out_valid_reg <= 1'b0;
            cwrap_reg     <= '0;
            awrap_reg     <= '0;
            for (int i = 0; i < NCOMB; i++)
            begin
                lowpass_reg[i] <= '0;
                cpos_reg[i]    <= '0;
            end
            for (int i = 0; i < NAP; i++)
            begin
                apos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // The output register loads a finished item or empties on a handshake.
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    side_reg <= 1'b0;
                    idx_reg  <= 2'd0;
                end
                ST_CM2:
                begin
                    lowpass_reg[cline] <= sat32(wide_t'(acc_reg) + wide_t'(prod_rnd));
                end
                ST_CM4:
                begin
                    if (cpos_inc >= {1'b0, clen})
                    begin
                        cpos_reg[cline]  <= '0;
                        cwrap_reg[cline] <= 1'b1;
                    end
                    else
                    begin
                        cpos_reg[cline] <= cpos_inc[CPOS_W-1:0];
                    end
                    idx_reg <= idx_reg + 2'd1;
                end
                ST_AP2:
                begin
                    if (apos_inc >= {1'b0, alen})
                    begin
                        apos_reg[aline]  <= '0;
                        awrap_reg[aline] <= 1'b1;
                    end
                    else
                    begin
                        apos_reg[aline] <= apos_inc[APOS_W-1:0];
                    end
                    idx_reg <= {1'b0, ~idx_reg[0]};
                end
                ST_MX5:
                begin
                    side_reg <= 1'b1;
                    idx_reg  <= 2'd0;
                end
                default:
                begin
                end
            endcase

            // Register writes; a new scale empties the delay lines.
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_FEEDBACK: cfg_fb_reg   <= cfg_data[14:0];
                    CFG_WET:      cfg_wet_reg  <= cfg_data[15:0];
                    CFG_GAIN:     cfg_gain_reg <= cfg_data[15:0];
                    CFG_SCALE:
                    begin
                        cfg_scale_reg <= cfg_data;
                        cwrap_reg     <= '0;
                        awrap_reg     <= '0;
                        for (int i = 0; i < NCOMB; i++)
                        begin
                            lowpass_reg[i] <= '0;
                            cpos_reg[i]    <= '0;
                        end
                        for (int i = 0; i < NAP; i++)
                        begin
                            apos_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dry_l_reg  <= s_tdata[SAMPLE_BITS-1:0];
                    dry_r_reg  <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                    fb_reg     <= fb_clamp;
                    dry_c_reg  <= 16'(17'd32768 - tenth);
                    wet_c_reg  <= wet_p2[15:2];
                    gain_reg   <= gain_sat;
                    bypass_reg <= (wet_sat <= WET_BYPASS);
                end
            end
            ST_IN:
            begin
                sum_reg <= '0;
            end
            ST_CRD:
            begin
                if (idx_reg == 2'd0)
                    in_reg <= prod_rnd[31:0];
            end
            ST_CM1:
            begin
                acc_reg <= prod_rnd;
                sum_reg <= sat32(wide_t'(sum_reg) + wide_t'(o_c));
            end
            ST_AP1:
            begin
                b_reg <= b_c;
            end
            ST_AP2:
            begin
                sum_reg <= sat32(wide_t'(b_reg) - wide_t'(sum_reg));
            end
            ST_MX2:
            begin
                acc_reg <= prod_rnd;
            end
            ST_MX3:
            begin
                mix_reg <= mul_a_t'(wide_t'(acc_reg) + wide_t'(prod_rnd));
            end
            ST_MX5:
            begin
                if (side_reg)
                    res_r_reg <= out_sat;
                else
                    res_l_reg <= out_sat;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_l_reg <= res_l_reg;
                    out_r_reg <= res_r_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Delay memories: one access per cycle, registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CRD)
            comb_rd_reg <= comb_mem[caddr];
        if (state_reg == ST_CM4)
            comb_mem[caddr] <= cwr;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ARD)
            ap_rd_reg <= ap_mem[aaddr];
        if (state_reg == ST_AP2)
            ap_mem[aaddr] <= awr;
    end

    // An accepted item keeps the sequencer busy in the next cycle.
    `SCAR_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready)
    // A finished item always reaches the output register.
    `SCAR_NEXT(a_done_loads, (state_reg == ST_DONE) && out_free, m_tvalid)
    // Comb write positions never reach the line length.
    `SCAR_IMPLIES(a_comb_pos, state_reg == ST_CM4, cpos_reg[cline] < clen)

endmodule

`default_nettype wire
